@@ sv/kbd_ar_pkg.sv @@
package kbd_ar_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned INDEX_W = 8;

  localparam logic [KEY_W-1:0] UPPER_LO    = 8'd64;
  localparam logic [KEY_W-1:0] UPPER_HI    = 8'd91;
  localparam logic [KEY_W-1:0] CASE_OFFSET = 8'd32;

  localparam logic [CNT_W-1:0] START_DELAY_RST   = 8'd25;
  localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 8'd5;
  localparam logic [CNT_W-1:0] FLASH_PERIOD_RST  = 8'd16;

  typedef enum logic [INDEX_W-1:0] {
    REG_START_DELAY   = 8'd0,
    REG_REPEAT_PERIOD = 8'd1,
    REG_FLASH_PERIOD  = 8'd2
  } reg_index_t;

  typedef struct packed {
    logic [CNT_W-1:0] start_delay;
    logic [CNT_W-1:0] repeat_period;
    logic [CNT_W-1:0] flash_period;
  } cfg_t;

  // Upper-case letters map onto their lower-case codes.
  function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] c);
    logic [KEY_W-1:0] r;
    r = c;
    if (c > UPPER_LO && c < UPPER_HI) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ sv/kbd_ar_poll_if.sv @@
interface kbd_ar_poll_if;
  logic                         valid;
  logic                         ready;
  logic [kbd_ar_pkg::KEY_W-1:0] key_sample;

  modport source (output valid, output key_sample, input ready);
  modport sink (input valid, input key_sample, output ready);
endinterface

@@ sv/kbd_ar_result_if.sv @@
interface kbd_ar_result_if;
  logic                         valid;
  logic                         ready;
  logic                         key_valid;
  logic [kbd_ar_pkg::KEY_W-1:0] key_code;
  logic                         cursor_inverted;

  modport source (output valid, output key_valid, output key_code,
                  output cursor_inverted, input ready);
  modport sink (input valid, input key_valid, input key_code,
                input cursor_inverted, output ready);
endinterface

@@ sv/kbd_ar_cfg_if.sv @@
interface kbd_ar_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kbd_ar_pkg::INDEX_W-1:0] index;
  logic [kbd_ar_pkg::CNT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/kbd_ar_regs.sv @@
module kbd_ar_regs (
  input  logic              clk,
  input  logic              rst,
  kbd_ar_cfg_if.sink        cfg,
  output kbd_ar_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_delay   <= kbd_ar_pkg::START_DELAY_RST;
      regs.repeat_period <= kbd_ar_pkg::REPEAT_PERIOD_RST;
      regs.flash_period  <= kbd_ar_pkg::FLASH_PERIOD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        kbd_ar_pkg::REG_START_DELAY:   regs.start_delay   <= cfg.data;
        kbd_ar_pkg::REG_REPEAT_PERIOD: regs.repeat_period <= cfg.data;
        kbd_ar_pkg::REG_FLASH_PERIOD:  regs.flash_period  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/kbd_ar_core.sv @@
module kbd_ar_core (
  input  logic              clk,
  input  logic              rst,
  input  kbd_ar_pkg::cfg_t  regs,
  kbd_ar_poll_if.sink       poll,
  kbd_ar_result_if.source   result
);

  localparam int unsigned KW = kbd_ar_pkg::KEY_W;
  localparam int unsigned CW = kbd_ar_pkg::CNT_W;

  logic          s1_valid;
  logic [KW-1:0] s1_key;
  logic          advance;
  logic          fire;

  logic [KW-1:0] held_key,       held_key_next;
  logic          holding_phase,  holding_phase_next;
  logic [CW-1:0] repeat_count,   repeat_count_next;
  logic          repeating_flag, repeating_flag_next;
  logic [CW-1:0] blink_count,    blink_count_next;
  logic          cursor_bit,     cursor_bit_next;
  logic          deliver;
  logic [CW-1:0] blink_dec;
  logic [CW-1:0] repeat_dec;

  assign advance    = !result.valid || result.ready;
  assign fire       = s1_valid && advance;
  assign poll.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_key <= poll.key_sample;
    end
  end

  assign blink_dec  = blink_count - 1'b1;
  assign repeat_dec = repeat_count - 1'b1;

  always_comb begin
    held_key_next       = held_key;
    holding_phase_next  = holding_phase;
    repeat_count_next   = repeat_count;
    repeating_flag_next = repeating_flag;
    blink_count_next    = blink_dec;
    cursor_bit_next     = cursor_bit;
    deliver             = 1'b0;

    if (blink_dec == '0) begin
      cursor_bit_next  = !cursor_bit;
      blink_count_next = regs.flash_period;
    end

    if (holding_phase) begin
      repeat_count_next = repeat_dec;
      if (repeat_dec == '0) begin
        if (!repeating_flag) begin
          repeating_flag_next = 1'b1;
          repeat_count_next   = regs.start_delay;
        end else begin
          repeat_count_next = regs.repeat_period;
        end
        holding_phase_next = 1'b0;
      end else if (kbd_ar_pkg::fold_case(s1_key) != kbd_ar_pkg::fold_case(held_key)) begin
        repeat_count_next = regs.start_delay;
        if (s1_key != '0) begin
          deliver = 1'b1;
        end else begin
          repeating_flag_next = 1'b0;
          holding_phase_next  = 1'b0;
        end
      end
    end else begin
      if (s1_key != '0) begin
        deliver = 1'b1;
      end else begin
        repeating_flag_next = 1'b0;
      end
    end

    if (deliver) begin
      held_key_next      = s1_key;
      holding_phase_next = 1'b1;
      cursor_bit_next    = 1'b0;
      blink_count_next   = regs.flash_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_key       <= '0;
      holding_phase  <= 1'b0;
      repeat_count   <= kbd_ar_pkg::START_DELAY_RST;
      repeating_flag <= 1'b0;
      blink_count    <= kbd_ar_pkg::FLASH_PERIOD_RST;
      cursor_bit     <= 1'b0;
    end else if (fire) begin
      held_key       <= held_key_next;
      holding_phase  <= holding_phase_next;
      repeat_count   <= repeat_count_next;
      repeating_flag <= repeating_flag_next;
      blink_count    <= blink_count_next;
      cursor_bit     <= cursor_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.key_valid       <= deliver;
      result.key_code        <= deliver ? s1_key : '0;
      result.cursor_inverted <= cursor_bit_next;
    end
  end

`ifndef SYNTHESIS
  a_delivery_clears_cursor: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.key_valid |-> !result.cursor_inverted)
    else $error("delivered item shows an inverted cursor");

  a_idle_code_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.key_valid |-> result.key_code == '0)
    else $error("key code not zero without a delivery");

  a_delivery_holds: assert property (@(posedge clk) disable iff (rst)
    fire && deliver |=> holding_phase && held_key == $past(s1_key))
    else $error("delivery did not enter the holding phase");

  a_stall_keeps_state: assert property (@(posedge clk) disable iff (rst)
    !fire && !$past(rst) |=> $stable(repeat_count) && $stable(blink_count))
    else $error("counters moved without a poll");
`endif

endmodule

@@ sv/keyboard_autorepeat_cursor_flash.sv @@
// Channel  Role    Payload
// poll     sink    key_sample[7:0]
// result   source  key_valid, key_code[7:0], cursor_inverted
// cfg      sink    index[7:0], data[7:0]
//
// One poll item enters per cycle unless both stages are full and the result is stalled.
// The poll is registered, then one pass of counter and compare logic fills the
// result register. A stalled result holds both stages; the poll side stalls only
// when both are full. Reset is synchronous and restores the register defaults.
module keyboard_autorepeat_cursor_flash (
  input  logic            clk,
  input  logic            rst,
  kbd_ar_poll_if.sink     poll,
  kbd_ar_result_if.source result,
  kbd_ar_cfg_if.sink      cfg
);

  kbd_ar_pkg::cfg_t regs;

  kbd_ar_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  kbd_ar_core u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .poll   (poll),
    .result (result)
  );

endmodule

@@ sim/tb_keyboard_autorepeat_cursor_flash.sv @@
module tb_keyboard_autorepeat_cursor_flash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned        INDEX_W      = kbd_ar_pkg::INDEX_W;
  localparam int unsigned        KEY_W        = kbd_ar_pkg::KEY_W;
  localparam int unsigned        CNT_W        = kbd_ar_pkg::CNT_W;

  localparam logic [INDEX_W-1:0] REG_UNMAPPED = 8'd3;
  localparam logic [KEY_W-1:0]   UPPER_A      = 8'h41;
  localparam logic [KEY_W-1:0]   UPPER_Z      = 8'h5A;
  localparam logic [KEY_W-1:0]   LOWER_A      = 8'h61;
  localparam logic [KEY_W-1:0]   LOWER_Z      = 8'h7A;
  localparam logic [KEY_W-1:0]   CASE_BIT     = 8'h20;
  localparam int unsigned        STALL_LIMIT  = 1000;

  typedef struct packed {
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
    logic             cursor_inverted;
  } key_result_t;

  logic clk;
  logic rst;

  kbd_ar_poll_if   poll_ch ();
  kbd_ar_result_if result_ch ();
  kbd_ar_cfg_if    cfg_ch ();

  keyboard_autorepeat_cursor_flash uut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [KEY_W-1:0] pending_polls[$];
  key_result_t      expected_results[$];
  key_result_t      want;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      err_count;
  int unsigned      stall_cycles;
  int unsigned      typed_count;

  // Typematic state as the block should hold it.
  logic [CNT_W-1:0] start_delay;
  logic [CNT_W-1:0] repeat_period;
  logic [CNT_W-1:0] flash_period;
  logic [KEY_W-1:0] held_code;
  logic             holding;
  logic [CNT_W-1:0] repeat_left;
  logic             repeating;
  logic [CNT_W-1:0] blink_left;
  logic             cursor_on;

  function automatic logic [KEY_W-1:0] lower_letter(input logic [KEY_W-1:0] c);
    return (c >= UPPER_A && c <= UPPER_Z) ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic is_letter(input logic [KEY_W-1:0] c);
    return (c | CASE_BIT) >= LOWER_A && (c | CASE_BIT) <= LOWER_Z;
  endfunction

  task automatic predict_poll(input logic [KEY_W-1:0] sample);
    key_result_t r;
    logic        deliver;
    deliver = 1'b0;
    blink_left = blink_left - 1'b1;
    if (blink_left == '0) begin
      cursor_on = ~cursor_on;
      blink_left = flash_period;
    end
    if (holding) begin
      repeat_left = repeat_left - 1'b1;
      if (repeat_left == '0) begin
        if (!repeating) begin
          repeating = 1'b1;
          repeat_left = start_delay;
        end else begin
          repeat_left = repeat_period;
        end
        holding = 1'b0;
      end else if (lower_letter(sample) != lower_letter(held_code)) begin
        repeat_left = start_delay;
        if (sample != '0) begin
          deliver = 1'b1;
        end else begin
          repeating = 1'b0;
          holding = 1'b0;
        end
      end
    end else if (sample != '0) begin
      deliver = 1'b1;
    end else begin
      repeating = 1'b0;
    end
    if (deliver) begin
      held_code = sample;
      holding = 1'b1;
      cursor_on = 1'b0;
      blink_left = flash_period;
    end
    r.key_valid = deliver;
    r.key_code = deliver ? sample : '0;
    r.cursor_inverted = cursor_on;
    expected_results.push_back(r);
  endtask

  task automatic push_poll(input logic [KEY_W-1:0] k);
    pending_polls.push_back(k);
    typed_count++;
  endtask

  task automatic wait_drained();
    while (pending_polls.size() != 0 || poll_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      kbd_ar_pkg::REG_START_DELAY:   start_delay = value;
      kbd_ar_pkg::REG_REPEAT_PERIOD: repeat_period = value;
      kbd_ar_pkg::REG_FLASH_PERIOD:  flash_period = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic pick_key(output logic [KEY_W-1:0] k);
    if ($urandom_range(1) == 0) begin
      k = LOWER_A + KEY_W'($urandom_range(25));
      if ($urandom_range(1) == 0) begin
        k = k ^ CASE_BIT;
      end
    end else begin
      k = KEY_W'($urandom_range(1, 255));
    end
  endtask

  // Mostly press, hold and release runs; a share of rolls, case flips and noise.
  task automatic queue_typing(input int unsigned n_items);
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] other;
    int unsigned      span;
    int unsigned      len;
    int unsigned      roll;
    typed_count = 0;
    while (typed_count < n_items) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 6)) push_poll(KEY_W'($urandom));
      end else begin
        pick_key(k);
        span = (start_delay == '0 ? 256 : start_delay)
             + 4 * (repeat_period == '0 ? 256 : repeat_period) + 3;
        if ($urandom_range(7) == 0) begin
          len = $urandom_range(1, span > 300 ? 300 : span);
        end else begin
          len = $urandom_range(1, span > 40 ? 40 : span);
        end
        if (len > n_items - typed_count) begin
          len = n_items - typed_count;
        end
        repeat (len) begin
          roll = $urandom_range(99);
          if (roll < 12 && is_letter(k)) begin
            push_poll(k ^ CASE_BIT);
          end else if (roll < 15) begin
            pick_key(other);
            push_poll(other);
          end else begin
            push_poll(k);
          end
        end
        repeat ($urandom_range(0, 3)) push_poll('0);
      end
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] sd, input logic [CNT_W-1:0] rp,
                           input logic [CNT_W-1:0] fp, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned n_items);
    wait_drained();
    write_reg(kbd_ar_pkg::REG_START_DELAY, sd);
    write_reg(kbd_ar_pkg::REG_REPEAT_PERIOD, rp);
    write_reg(kbd_ar_pkg::REG_FLASH_PERIOD, fp);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_typing(n_items);
  endtask

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      poll_ch.valid <= 1'b0;
      poll_ch.key_sample <= '0;
    end else begin
      if (poll_ch.valid && poll_ch.ready) begin
        predict_poll(poll_ch.key_sample);
      end
      if (!poll_ch.valid || poll_ch.ready) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          poll_ch.valid <= 1'b1;
          poll_ch.key_sample <= pending_polls.pop_front();
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected item: key_valid %0d key_code %0d cursor_inverted %0d",
                 result_ch.key_valid, result_ch.key_code, result_ch.cursor_inverted);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_ch.key_valid !== want.key_valid) begin
            $error("key_valid: expected %0d, got %0d", want.key_valid, result_ch.key_valid);
            err_count++;
          end
          if (result_ch.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, result_ch.key_code);
            err_count++;
          end
          if (result_ch.cursor_inverted !== want.cursor_inverted) begin
            $error("cursor_inverted: expected %0d, got %0d", want.cursor_inverted,
                   result_ch.cursor_inverted);
            err_count++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)
        || (pending_polls.size() == 0 && expected_results.size() == 0 && !poll_ch.valid
            && !cfg_ch.valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_keyboard_autorepeat_cursor_flash: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    poll_ch.valid = 1'b0;
    poll_ch.key_sample = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    stall_cycles = 0;
    start_delay = kbd_ar_pkg::START_DELAY_RST;
    repeat_period = kbd_ar_pkg::REPEAT_PERIOD_RST;
    flash_period = kbd_ar_pkg::FLASH_PERIOD_RST;
    held_code = '0;
    holding = 1'b0;
    repeat_left = kbd_ar_pkg::START_DELAY_RST;
    repeating = 1'b0;
    blink_left = kbd_ar_pkg::FLASH_PERIOD_RST;
    cursor_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the key code, case folding and the letter range boundaries.
    push_poll(8'h00);
    push_poll(8'h01);
    push_poll(8'hFF);
    push_poll(8'hFF);
    push_poll(8'h80);
    push_poll(8'h00);
    push_poll(8'h41);
    push_poll(8'h61);
    push_poll(8'h5A);
    push_poll(8'h7A);
    push_poll(8'h40);
    push_poll(8'h60);
    push_poll(8'h5B);
    push_poll(8'h7B);
    push_poll(8'h55);
    push_poll(8'hAA);
    push_poll(8'h00);

    // Short delays so that a hold expires and a new key lands on an expiry.
    wait_drained();
    write_reg(kbd_ar_pkg::REG_START_DELAY, 8'd2);
    write_reg(kbd_ar_pkg::REG_REPEAT_PERIOD, 8'd1);
    write_reg(kbd_ar_pkg::REG_FLASH_PERIOD, 8'd3);
    write_reg(REG_UNMAPPED, 8'd9);
    repeat (5) push_poll(8'h6B);
    push_poll(8'h4B);
    push_poll(8'h6D);
    push_poll(8'h6D);
    push_poll(8'h00);

    run_phase(8'd1, 8'd1, 8'd1, 0, 0, 105);
    run_phase(8'd255, 8'd255, 8'd255, 55, 0, 105);
    run_phase(8'd3, 8'd2, 8'd4, 0, 55, 105);
    run_phase(8'd0, 8'd0, 8'd0, 33, 33, 105);
    run_phase(kbd_ar_pkg::START_DELAY_RST, kbd_ar_pkg::REPEAT_PERIOD_RST,
              kbd_ar_pkg::FLASH_PERIOD_RST, 0, 0, 105);
    run_phase(CNT_W'($urandom_range(1, 12)), CNT_W'($urandom_range(1, 12)),
              CNT_W'($urandom_range(1, 12)), 55, 0, 105);
    run_phase(CNT_W'($urandom_range(1, 40)), CNT_W'($urandom_range(1, 10)),
              CNT_W'($urandom_range(1, 30)), 0, 55, 105);
    run_phase(CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(1, 4)),
              CNT_W'($urandom_range(1, 255)), 33, 33, 105);

    wait_drained();
    repeat (2) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_keyboard_autorepeat_cursor_flash: done, clean");
    end else begin
      $display("tb_keyboard_autorepeat_cursor_flash: done, errors");
    end
    $finish;
  end

endmodule
